### rtl/core/md5p_pkg.sv
// md5 message padder package: job record handed from the byte packer to the word sequencer
// and block position constants; no dependencies
package md5p_pkg;

    localparam int WORD_W  = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 61;
    localparam int LEN_W   = 64;

    localparam logic [POS_W-1:0] LEN_LO_POS = 4'd14;
    localparam logic [POS_W-1:0] LEN_HI_POS = 4'd15;
    localparam logic [7:0]       PAD_BYTE   = 8'h80;

    // words still owed for one accepted beat
    typedef struct packed {
        logic              has_data;
        logic [WORD_W-1:0] data_word;
        logic [POS_W-1:0]  data_pos;
        logic              has_tail;
        logic              first_pend;
        logic              low_done;
        logic [WORD_W-1:0] first_word;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  bits;
    } t_job;

endpackage

### rtl/core/md5p_if.sv
// valid/ready channel interfaces for the md5 message padder
// byte input channel and padded word output channel; no dependencies
interface md5p_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output msg_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input msg_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

interface md5p_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] padded_word;
    logic [3:0]  word_position;
    logic        final_word;

    modport source (output valid, output padded_word, output word_position,
                    output final_word, input ready);
    modport sink   (input valid, input padded_word, input word_position,
                    input final_word, output ready);
endinterface

### rtl/core/md5_message_padder.sv
// md5 message padder top level: packs bytes into little-endian words and builds the
// padding and length tail; depends on md5p_pkg, md5p_if and md5p_emit
// path: a completed word passes through the sequencer's job register and then its output register
// throughput: one byte beat per cycle while output is ready; an end beat emits 3 to 19
//   words, one per ready cycle; the sequencer holds input off until its last word leaves
// reset: synchronous active low, clears byte count, partial word and all pending output
module md5_message_padder
    import md5p_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    md5p_in_if.sink    i_msg,
    md5p_out_if.source o_word
);

    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [23:0]        r_partial, n_partial;
    logic [1:0]         r_bytes_in_word, n_bytes_in_word;

    logic               job_free;
    logic               accept;
    logic               data_done;
    logic [WORD_W-1:0]  packed_word;
    logic [COUNT_W-1:0] cnt_after;
    logic [23:0]        part_after;
    logic [1:0]         slot_after;
    logic               load;
    t_job               job;

    assign i_msg.ready = job_free;
    assign accept      = i_msg.valid && job_free;

    always_comb begin
        packed_word = {8'd0, r_partial}
                    | ({24'd0, i_msg.msg_byte} << {r_bytes_in_word, 3'b000});
        data_done   = i_msg.byte_present && (r_bytes_in_word == 2'd3);
        cnt_after   = r_byte_count;
        part_after  = r_partial;
        slot_after  = r_bytes_in_word;
        if (i_msg.byte_present) begin
            cnt_after = r_byte_count + 1'b1;
            if (data_done) begin
                part_after = '0;
                slot_after = '0;
            end else begin
                part_after = packed_word[23:0];
                slot_after = r_bytes_in_word + 1'b1;
            end
        end

        job.has_data   = data_done;
        job.data_word  = packed_word;
        job.data_pos   = r_byte_count[5:2];
        job.has_tail   = i_msg.end_of_message;
        job.first_pend = 1'b1;
        job.low_done   = 1'b0;
        job.first_word = {8'd0, part_after}
                       | ({24'd0, PAD_BYTE} << {slot_after, 3'b000});
        job.pos        = cnt_after[5:2];
        job.bits       = {cnt_after, 3'b000};

        load = accept && (data_done || i_msg.end_of_message);

        n_byte_count    = r_byte_count;
        n_partial       = r_partial;
        n_bytes_in_word = r_bytes_in_word;
        if (accept) begin
            if (i_msg.end_of_message) begin
                // message closed, start over for the next one
                n_byte_count    = '0;
                n_partial       = '0;
                n_bytes_in_word = '0;
            end else begin
                n_byte_count    = cnt_after;
                n_partial       = part_after;
                n_bytes_in_word = slot_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_partial       <= '0;
            r_bytes_in_word <= '0;
        end else begin
            r_byte_count    <= n_byte_count;
            r_partial       <= n_partial;
            r_bytes_in_word <= n_bytes_in_word;
        end
    end

    md5p_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_job      (job),
        .o_job_free (job_free),
        .o_word     (o_word)
    );

endmodule

### rtl/core/md5p_emit.sv
// md5 padder word sequencer: holds one job and emits its words, one per cycle when
// not stalled, into a registered output; depends on md5p_pkg and md5p_out_if
module md5p_emit
    import md5p_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_job        i_job,
    output logic        o_job_free,
    md5p_out_if.source  o_word
);

    t_job              r_job, n_job;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_final;

    logic              busy;
    logic              out_free;
    logic              emit;
    logic              last;
    logic [WORD_W-1:0] sel_word;
    logic [POS_W-1:0]  sel_pos;
    logic              sel_final;

    assign busy     = r_job.has_data | r_job.has_tail;
    assign out_free = !r_out_valid || o_word.ready;
    assign emit     = busy && out_free;

    always_comb begin
        sel_word  = '0;
        sel_pos   = r_job.pos;
        sel_final = 1'b0;
        last      = 1'b0;
        if (r_job.has_data) begin
            sel_word = r_job.data_word;
            sel_pos  = r_job.data_pos;
            last     = !r_job.has_tail;
        end else if (r_job.first_pend) begin
            sel_word = r_job.first_word;
        end else if (r_job.low_done) begin
            // high length word closes the message
            sel_word  = r_job.bits[LEN_W-1:WORD_W];
            sel_final = 1'b1;
            last      = 1'b1;
        end else if (r_job.pos == LEN_LO_POS) begin
            sel_word = r_job.bits[WORD_W-1:0];
        end
    end

    assign o_job_free = !busy || (last && out_free);

    always_comb begin
        n_job = r_job;
        if (i_load) begin
            n_job = i_job;
        end else if (emit) begin
            if (r_job.has_data) begin
                n_job.has_data = 1'b0;
            end else begin
                n_job.pos        = r_job.pos + 1'b1;
                n_job.first_pend = 1'b0;
                if (!r_job.first_pend && r_job.pos == LEN_LO_POS) begin
                    n_job.low_done = 1'b1;
                end
                if (last) begin
                    n_job.has_tail = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_job <= n_job;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
        if (out_free) begin
            r_out_word  <= sel_word;
            r_out_pos   <= sel_pos;
            r_out_final <= sel_final;
        end
    end

    assign o_word.valid         = r_out_valid;
    assign o_word.padded_word   = r_out_word;
    assign o_word.word_position = r_out_pos;
    assign o_word.final_word    = r_out_final;

endmodule

### tb/sv/testbench.sv
// self-checking testbench for md5_message_padder: drives byte beats, predicts the padded
// word stream and checks every output beat in order
// depends on md5p_pkg, md5p_if (md5p_in_if, md5p_out_if) and the md5_message_padder rtl
module testbench;
    import md5p_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;
        logic              fin;
    } t_padded_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    md5p_in_if  msg_if ();
    md5p_out_if word_if ();

    md5_message_padder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if),
        .o_word  (word_if)
    );

    // predictor state
    logic [COUNT_W-1:0] msg_byte_count;
    logic [23:0]        partial_bytes;
    logic [1:0]         partial_fill;
    t_padded_word       pending_words[$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int errors = 0;
    int beats_sent = 0;
    int words_checked = 0;
    int messages_done = 0;
    int cycles = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $time, pending_words.size());
            $display("** md5_message_padder: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        word_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    function automatic void predict_padded_words(input logic [7:0] b, input logic present,
                                                 input logic eom);
        logic [WORD_W-1:0] w;
        logic [POS_W-1:0]  idx;
        logic [LEN_W-1:0]  bitlen;
        if (present) begin
            w = {8'h00, partial_bytes} | ({24'h0, b} << (8 * partial_fill));
            idx = msg_byte_count[5:2];
            msg_byte_count = msg_byte_count + 1'b1;
            if (partial_fill == 2'd3) begin
                pending_words.push_back('{w, idx, 1'b0});
                partial_bytes = '0;
                partial_fill = '0;
            end else begin
                partial_bytes = w[23:0];
                partial_fill = partial_fill + 1'b1;
            end
        end
        if (eom) begin
            bitlen = {msg_byte_count, 3'b000};
            idx = msg_byte_count[5:2];
            w = {8'h00, partial_bytes} | ({24'h0, PAD_BYTE} << (8 * partial_fill));
            pending_words.push_back('{w, idx, 1'b0});
            idx = idx + 1'b1;
            // zero fill up to the length words, wrapping into the next block if needed
            while (idx != LEN_LO_POS) begin
                pending_words.push_back('{'0, idx, 1'b0});
                idx = idx + 1'b1;
            end
            pending_words.push_back('{bitlen[31:0], LEN_LO_POS, 1'b0});
            pending_words.push_back('{bitlen[63:32], LEN_HI_POS, 1'b1});
            msg_byte_count = '0;
            partial_bytes = '0;
            partial_fill = '0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_padded_word got;
        t_padded_word want;
        if (i_rst_n === 1'b1) begin
            if (msg_if.valid && msg_if.ready) begin
                predict_padded_words(msg_if.msg_byte, msg_if.byte_present,
                                     msg_if.end_of_message);
                if (msg_if.end_of_message) messages_done++;
            end
            if (word_if.valid && word_if.ready) begin
                got = '{word_if.padded_word, word_if.word_position, word_if.final_word};
                words_checked++;
                if (pending_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual %h pos %0d final %0b",
                             $time, got.word, got.pos, got.fin);
                end else begin
                    want = pending_words.pop_front();
                    check_field("padded_word", want.word, got.word);
                    check_field("word_position", 32'(want.pos), 32'(got.pos));
                    check_field("final_word", 32'(want.fin), 32'(got.fin));
                end
            end
        end
    end

    // holds valid high until the beat is taken; returns at the accepting edge
    task automatic send_beat(input logic [7:0] b, input logic present, input logic eom);
        while ($urandom_range(99) < src_idle_pct) begin
            msg_if.valid <= 1'b0;
            msg_if.msg_byte <= 8'($urandom);
            @(posedge i_clk);
        end
        msg_if.valid <= 1'b1;
        msg_if.msg_byte <= b;
        msg_if.byte_present <= present;
        msg_if.end_of_message <= eom;
        do @(posedge i_clk); while (!(msg_if.ready === 1'b1));
        if (present || eom) beats_sent++;
    endtask

    task automatic wait_all_words();
        msg_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    task automatic send_message(input int unsigned len, input bit end_with_byte,
                                input int unsigned noise_pct);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(99) < noise_pct) send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
        end
        if (!end_with_byte || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_empty_message();
        send_beat(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_byte_with_end();
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_word_fill();
        // three bytes then a bare end: pad byte lands in the top lane
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'hA5, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        // a full word ended on its last byte: pad starts a fresh word
        send_beat(8'h5A, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h81, 1'b1, 1'b1);
    endtask

    task automatic test_idle_items();
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h3C, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'hC3, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_random_messages(input int src_pct, input int snk_pct,
                                        input int target_beats);
        int start_beats;
        int unsigned len;
        int unsigned pick;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        start_beats = beats_sent;
        while (beats_sent - start_beats < target_beats) begin
            pick = $urandom_range(9);
            // bias toward lengths near where the pad spills into a second block
            if (pick < 4) begin
                case ($urandom_range(6))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    5: len = 60;
                    default: len = 52;
                endcase
            end else if (pick == 9) begin
                len = $urandom_range(100, 130);
            end else begin
                len = $urandom_range(0, 20);
            end
            send_message(len, 1'($urandom_range(1)), 8);
        end
        wait_all_words();
    endtask

    initial begin
        i_rst_n = 1'b0;
        msg_if.valid = 1'b0;
        msg_if.msg_byte = '0;
        msg_if.byte_present = 1'b0;
        msg_if.end_of_message = 1'b0;
        word_if.ready = 1'b0;
        msg_byte_count = '0;
        partial_bytes = '0;
        partial_fill = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 33;
        snk_idle_pct = 82;
        test_empty_message();
        test_byte_with_end();
        test_word_fill();
        test_idle_items();
        wait_all_words();

        test_random_messages(33, 82, 35);
        test_random_messages(82, 33, 35);
        test_random_messages(0, 0, 35);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            errors++;
            $display("%0t: %0d expected words never arrived", $time, pending_words.size());
        end
        $display("covered %0d byte and end beats in %0d messages, %0d padded words checked",
                 beats_sent, messages_done, words_checked);
        $display("%0d mismatches over %0d cycles", errors, cycles);
        if (errors == 0) begin
            $display("** md5_message_padder: PASSED **");
        end else begin
            $display("** md5_message_padder: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/md5p_pkg.sv
rtl/core/md5p_if.sv
rtl/core/md5p_emit.sv
rtl/core/md5_message_padder.sv
tb/sv/testbench.sv
